[hw/rtl/hsc128_pkg.sv]
package hsc128_pkg;

  localparam int unsigned GROUPS      = 7;
  localparam int unsigned ENTRY_W     = 128;
  localparam int unsigned SLICE_W     = 16;
  localparam int unsigned SLICES      = ENTRY_W / SLICE_W;
  // Data bits from this index up sit above the ECC byte and are shifted past it.
  localparam logic [7:0]  ECC_SKIP_AT = 8'd24;
  localparam logic [7:0]  ECC_BYTE_W  = 8'd8;
  // Check-bit positions map downward from word-0 bit 31.
  localparam logic [6:0]  CHECK_TOP   = 7'd32;

  // Group masks over the whole entry, word 3 in the top bits down to word 0.
  localparam logic [ENTRY_W-1:0] GRP_MASK [GROUPS] = '{
    128'hAAAAAAAA_AAAAAAAB_55555556_80AAAD5B,
    128'hCCCCCCCC_CCCCCCCD_9999999B_4033366D,
    128'hF0F0F0F0_F0F0F0F1_E1E1E1E3_20C3C78E,
    128'hFF00FF00_FF00FF01_FE01FE03_10FC07F0,
    128'hFFFF0000_FFFF0001_FFFE0003_08FFF800,
    128'hFFFFFFFF_00000001_FFFFFFFC_04000000,
    128'hFFFFFFFF_FFFFFFFE_00000000_02000000
  };

  typedef enum logic {
    ACT_COMPUTE = 1'b0,
    ACT_CORRECT = 1'b1
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [63:0] entry_low;
    logic [63:0] entry_high;
    logic [6:0]  syndrome_in;
  } in_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic [6:0]  check_bits;
    logic        overall_parity;
    logic [6:0]  flipped_bit;
    logic        did_flip;
  } out_t;

  // Number of significant bits in a 7-bit value.
  function automatic logic [2:0] bit_len(input logic [6:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (v[i]) n = 3'(i + 1);
    end
    return n;
  endfunction

endpackage

[hw/rtl/hamming_secded_128_check_correct.sv]
// SEC-DED check and correct for one 128-bit entry (four 32-bit words, with
// the ECC byte in bits 31..24 of word 0).
// Input channel: item is taken at a rising edge where start is high and busy
// is low. busy is always low, so a beat can be issued on every cycle.
// item.action selects compute mode (seven group parities plus the overall
// parity of all 128 bits) or correct mode (a nonzero syndrome_in is mapped to
// an entry bit, a data bit or a check bit, which is flipped and reported).
// Result channel: result is valid for exactly one cycle while done is high.
// Throughput is one beat per cycle; the three register stages (partial
// parities and position decode, parity reduction and index mapping, bit
// flip) each hold a different beat, and done rises as the last one loads.
// Reset clears the stage valid bits, dropping any beats in flight; nothing
// else needs clearing. The receiver has no way to stall, so results are
// never held and nothing backs up into the pipeline.
module hamming_secded_128_check_correct (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hsc128_pkg::in_t  item,
  output logic             done,
  output hsc128_pkg::out_t result
);
  import hsc128_pkg::*;

  // Stage 1: entry slices and syndrome position.
  logic                     v1;
  in_t                      s1_item;
  logic [GROUPS-1:0][SLICES-1:0] s1_part;
  logic [SLICES-1:0]        s1_opart;
  logic [6:0]               s1_h;
  logic [2:0]               s1_len;
  logic                     s1_pow2;

  // Stage 2: final parities and flip index.
  logic                     v2;
  in_t                      s2_item;
  logic [6:0]               s2_chk;
  logic                     s2_ovr;
  logic [6:0]               s2_d;
  logic                     s2_did;

  logic [ENTRY_W-1:0]       entry;
  logic [GROUPS-1:0][SLICES-1:0] part_next;
  logic [SLICES-1:0]        opart_next;
  logic [6:0]               h_next;
  logic [6:0]               chk_next;
  logic [7:0]               dsum;
  logic [7:0]               dadj;
  logic [6:0]               d_next;
  logic [ENTRY_W-1:0]       s2_entry;
  logic [ENTRY_W-1:0]       flip_mask;
  logic [ENTRY_W-1:0]       fixed;
  out_t                     result_next;

  assign busy  = 1'b0;
  assign entry = {item.entry_high, item.entry_low};

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      for (int k = 0; k < SLICES; k++) begin
        part_next[g][k] = ^(entry[k*SLICE_W +: SLICE_W] & GRP_MASK[g][k*SLICE_W +: SLICE_W]);
      end
    end
    for (int k = 0; k < SLICES; k++) begin
      opart_next[k] = ^entry[k*SLICE_W +: SLICE_W];
    end
    // Group 1 sits in syndrome bit 6 but is the lowest bit of the position.
    for (int i = 0; i < 7; i++) begin
      h_next[i] = item.syndrome_in[6-i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    s1_item  <= item;
    s1_part  <= part_next;
    s1_opart <= opart_next;
    s1_h     <= h_next;
    s1_len   <= bit_len(h_next);
    s1_pow2  <= ((h_next & (h_next - 7'd1)) == 7'd0);
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      chk_next[6-g] = ^s1_part[g];
    end
    dsum = {1'b0, s1_h} - {5'd0, s1_len} - 8'd1;
    dadj = (dsum >= ECC_SKIP_AT) ? dsum + ECC_BYTE_W : dsum;
    if (s1_pow2) begin
      d_next = CHECK_TOP - {4'd0, s1_len};
    end else begin
      d_next = dadj[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2_item <= s1_item;
    s2_chk  <= (s1_item.action == ACT_COMPUTE) ? chk_next : 7'd0;
    s2_ovr  <= (s1_item.action == ACT_COMPUTE) ? ^s1_opart : 1'b0;
    s2_did  <= (s1_item.action == ACT_CORRECT) && (s1_h != 7'd0);
    s2_d    <= d_next;
  end

  always_comb begin
    s2_entry  = {s2_item.entry_high, s2_item.entry_low};
    flip_mask = s2_did ? (128'd1 << s2_d) : '0;
    fixed     = s2_entry ^ flip_mask;
    result_next.result_low     = fixed[63:0];
    result_next.result_high    = fixed[127:64];
    result_next.check_bits     = s2_chk;
    result_next.overall_parity = s2_ovr;
    result_next.flipped_bit    = s2_did ? s2_d : 7'd0;
    result_next.did_flip       = s2_did;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
    result <= result_next;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##3 done)
    else $error("accepted beat did not reach the result port after three cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3))
    else $error("result strobe without an accepted beat");

  a_mode_excl: assert property (@(posedge clk) disable iff (rst)
    done && result.did_flip |-> result.check_bits == 7'd0 && !result.overall_parity)
    else $error("parity reported on a corrected beat");

  a_flip_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.did_flip |-> result.flipped_bit == 7'd0)
    else $error("flip index set without a flip");
`endif

endmodule
